/* rtl/sllcp_pkg.sv */
`timescale 1ns / 1ps
package sllcp_pkg;
    localparam int NumWeights = 4096;
    localparam int AddrW = $clog2(NumWeights);
    localparam int SumW = 48;
    localparam int ScoreMax = 16383;
    localparam int ScoreMin = -16384;
    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

    typedef enum logic [2:0] {
        t_idle = 3'd0,
        t_read = 3'd1,
        t_exp  = 3'd2,
        t_div  = 3'd3,
        t_out  = 3'd4
    } t_state;

    function automatic logic [17:0] pow2_tab(input logic [4:0] i);
        logic [17:0] v;
        unique case (i)
            5'd0: v = 18'd65536;
            5'd1: v = 18'd68438;
            5'd2: v = 18'd71467;
            5'd3: v = 18'd74632;
            5'd4: v = 18'd77936;
            5'd5: v = 18'd81386;
            5'd6: v = 18'd84990;
            5'd7: v = 18'd88752;
            5'd8: v = 18'd92682;
            5'd9: v = 18'd96785;
            5'd10: v = 18'd101070;
            5'd11: v = 18'd105545;
            5'd12: v = 18'd110218;
            5'd13: v = 18'd115098;
            5'd14: v = 18'd120194;
            5'd15: v = 18'd125515;
            default: v = 18'd131072;
        endcase
        return v;
    endfunction
endpackage

/* rtl/sparse_log_linear_class_probability_core.sv */
`timescale 1ns / 1ps
// Weight write: taken while idle. Feature item: one weight store read.
// A class end also passes through the two-stage exponential.
// An example end runs the bit-serial divider, which is skipped when the denominator sum is zero.
// One item is in flight at a time; o_stall is low when idle, even with a word on the output.
// Synchronous active-low reset clears sums, score and control; weights are not cleared.
module sparse_log_linear_class_probability_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [11:0] i_weight_addr,
    input  logic signed [15:0] i_weight_value,
    input  logic [11:0] i_feature_index,
    input  logic        i_feature_valid,
    input  logic        i_end_of_class,
    input  logic        i_class_matches,
    input  logic        i_end_of_example,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_probability,
    output logic        o_no_classes
);
    import sllcp_pkg::*;
    t_state r_state, n_state;
    logic r_fv, r_eoc, r_match, r_eoe, r_ovalid, n_ovalid;
    logic signed [15:0] r_score, n_score;
    logic [SumW-1:0] r_num, n_num, r_den, n_den;
    logic [16:0] r_prob, n_prob;
    logic r_nc, n_nc;
    logic [15:0] rdata;
    logic [39:0] expv;
    logic signed [17:0] t;
    logic [SumW:0] sd, sn;
    logic accept, div_start, div_done, out_free;
    logic [16:0] div_q;

    assign accept = i_valid && !o_stall;
    assign o_stall = (r_state != t_idle);

    sllcp_wstore u_ws (
        .i_clk(i_clk),
        .i_we(accept && !i_op),
        .i_waddr(i_weight_addr),
        .i_wdata(i_weight_value),
        .i_raddr(i_feature_index),
        .o_rdata(rdata)
    );
    sllcp_exp u_exp (.i_clk(i_clk), .i_score(r_score), .o_exp(expv));
    sllcp_div u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(div_start),
        .i_num(r_num), .i_den(r_den), .o_done(div_done), .o_q(div_q)
    );

    always_comb begin
        n_state = r_state; n_score = r_score; n_num = r_num; n_den = r_den;
        n_prob = r_prob; n_nc = r_nc; n_ovalid = r_ovalid && i_stall;
        div_start = 1'b0;
        // The output register can take a new word when empty or drained this cycle.
        out_free = !r_ovalid || !i_stall;
        t = 18'(r_score) + 18'($signed(rdata));
        sd = {1'b0, r_den} + {9'd0, expv};
        sn = {1'b0, r_num} + {9'd0, expv};
        unique case (r_state)
            t_idle: if (accept && i_op) n_state = t_read;
            t_read: begin
                if (r_fv) begin
                    if (t > 18'sd16383) n_score = 16'sd16383;
                    else if (t < -18'sd16384) n_score = -16'sd16384;
                    else n_score = t[15:0];
                end
                n_state = r_eoc ? t_exp : (r_eoe ? t_div : t_idle);
            end
            t_exp: n_state = t_out; // exponential pipeline fill
            t_out: begin
                n_den = sd[SumW] ? SumMax : sd[SumW-1:0];
                if (r_match) n_num = sn[SumW] ? SumMax : sn[SumW-1:0];
                n_score = '0;
                n_state = r_eoe ? t_div : t_idle;
            end
            t_div: begin
                if (r_den == '0) begin
                    if (out_free) begin
                        n_prob = '0; n_nc = 1'b1; n_ovalid = 1'b1;
                        n_num = '0; n_score = '0; n_state = t_idle;
                    end
                end else if (!r_fv) begin
                    div_start = 1'b1;
                end else if (div_done && out_free) begin
                    n_prob = div_q; n_nc = 1'b0; n_ovalid = 1'b1;
                    n_num = '0; n_den = '0; n_score = '0; n_state = t_idle;
                end
            end
            default: n_state = t_idle;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= t_idle; r_ovalid <= 1'b0; r_score <= '0;
            r_num <= '0; r_den <= '0; r_fv <= 1'b0;
        end else begin
            r_state <= n_state; r_ovalid <= n_ovalid; r_score <= n_score;
            r_num <= n_num; r_den <= n_den;
            if (accept) begin
                r_fv <= i_feature_valid && (32'(i_feature_index) < NumWeights);
            end else if (r_state == t_read) begin
                r_fv <= 1'b0;
            end else if (div_start) begin
                r_fv <= 1'b1;
            end
        end
        if (accept) begin
            r_eoc <= i_end_of_class; r_match <= i_class_matches; r_eoe <= i_end_of_example;
        end
        r_prob <= n_prob; r_nc <= n_nc;
    end

    assign o_valid = r_ovalid;
    assign o_probability = r_prob;
    assign o_no_classes = r_nc;

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != t_idle) |-> !accept) else $error("accept while busy");
    a_nc_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_nc) |-> (r_prob == 17'd0)) else $error("empty with prob");
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovalid |-> (r_prob <= 17'd65536)) else $error("prob range");
endmodule

/* rtl/sllcp_wstore.sv */
`timescale 1ns / 1ps
module sllcp_wstore (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [sllcp_pkg::AddrW-1:0] i_waddr,
    input  logic [15:0]               i_wdata,
    input  logic [sllcp_pkg::AddrW-1:0] i_raddr,
    output logic [15:0]               o_rdata
);
    import sllcp_pkg::*;
    logic [15:0] r_mem [NumWeights];
    logic [15:0] r_rdata;
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

/* rtl/sllcp_exp.sv */
`timescale 1ns / 1ps
// Two-stage exponential: log2 scaling, then table interpolation and shift.
module sllcp_exp (
    input  logic               i_clk,
    input  logic signed [15:0] i_score,
    output logic [39:0]        o_exp
);
    import sllcp_pkg::*;
    logic signed [33:0] r_p;
    logic [33:0] u;
    logic signed [7:0] k;
    logic [3:0] idx;
    logic [15:0] frac;
    logic [17:0] lo, hi;
    logic [33:0] prod;
    logic [17:0] m;
    logic [5:0] n;
    logic [57:0] wide;
    always_ff @(posedge i_clk) begin
        r_p <= 34'(i_score) * 34'sd94548;
    end
    always_comb begin
        u = r_p + (34'sd32 <<< 26);
        k = 8'($signed({2'b00, u[31:26]})) - 8'sd32;
        idx = u[25:22];
        frac = u[21:6];
        lo = pow2_tab({1'b0, idx});
        hi = pow2_tab({1'b0, idx} + 5'd1);
        prod = 34'(hi - lo) * 34'(frac) + 34'd32768;
        m = lo + 18'(prod >> 16);
        n = 6'(-k);
        if (k >= 0) begin
            wide = 58'(m) << k[4:0];
        end else begin
            wide = (58'(m) + (58'd1 << (n - 6'd1))) >> n;
        end
        o_exp = wide[39:0];
    end
endmodule

/* rtl/sllcp_div.sv */
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle, with round-to-nearest.
// o_done stays high from the end of a division until the next start.
module sllcp_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [sllcp_pkg::SumW-1:0] i_num,
    input  logic [sllcp_pkg::SumW-1:0] i_den,
    output logic                       o_done,
    output logic [16:0]                o_q
);
    import sllcp_pkg::*;
    localparam int NW = SumW + 16;
    logic [NW-1:0] r_n, n_n;
    logic [SumW:0] r_r, n_r;
    logic [SumW-1:0] r_d;
    logic [6:0] r_cnt, n_cnt;
    logic r_busy, n_busy, r_done, n_done;
    logic [NW-1:0] r_q, n_q;
    logic [SumW+1:0] sh;
    logic [NW:0] qr;
    always_comb begin
        n_n = r_n; n_r = r_r; n_cnt = r_cnt; n_busy = r_busy; n_done = r_done; n_q = r_q;
        sh = {r_r, r_n[NW-1]};
        if (i_start) begin
            n_n = {i_num, 16'd0}; n_r = '0; n_cnt = 7'(NW); n_busy = 1'b1; n_q = '0;
            n_done = 1'b0;
        end else if (r_busy) begin
            n_n = r_n << 1;
            if (sh >= {2'b00, r_d}) begin
                n_r = (SumW+1)'(sh - {2'b00, r_d});
                n_q = {r_q[NW-2:0], 1'b1};
            end else begin
                n_r = sh[SumW:0];
                n_q = {r_q[NW-2:0], 1'b0};
            end
            n_cnt = r_cnt - 7'd1;
            if (r_cnt == 7'd1) begin
                n_busy = 1'b0; n_done = 1'b1;
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0; r_done <= 1'b0; r_cnt <= '0;
        end else begin
            r_busy <= n_busy; r_done <= n_done; r_cnt <= n_cnt;
        end
        r_n <= n_n; r_r <= n_r; r_q <= n_q;
        if (i_start) r_d <= i_den;
    end
    always_comb begin
        qr = {1'b0, r_q} + (({r_r, 1'b0} >= {2'b00, r_d}) ? (NW+1)'(1) : '0);
        o_q = (qr > (NW+1)'(65536)) ? 17'd65536 : qr[16:0];
        o_done = r_done;
    end
endmodule
